@@ design/rlts_pkg.sv @@
// ----------------------------------------------------------------------------
// rlts_pkg
// Shared widths, stage counts and step functions for the radial light shader.
// ----------------------------------------------------------------------------
package rlts_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int TILE_W  = 11;
    localparam int POS_W   = 13;
    localparam int RANGE_W = 12;
    localparam int COL_W   = 8;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 13;

    localparam int DIFF_W = 14;
    localparam int ABS_W  = 13;
    localparam int SQ_W   = 26;
    localparam int SUM_W  = 27;

    localparam int RAD_W       = 36;
    localparam int ROOT_W      = 18;
    localparam int REM_W       = 20;
    localparam int SQRT_STAGES = 9;

    localparam int DEN_W      = 16;
    localparam int PROD_W     = 24;
    localparam int QUO_W      = 8;
    localparam int DIV_STAGES = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LIGHT_X     = 8'd0;
    localparam logic [IDX_W-1:0] REG_LIGHT_Y     = 8'd1;
    localparam logic [IDX_W-1:0] REG_LIGHT_RANGE = 8'd2;
    localparam logic [IDX_W-1:0] REG_LIGHT_RED   = 8'd3;
    localparam logic [IDX_W-1:0] REG_LIGHT_GREEN = 8'd4;
    localparam logic [IDX_W-1:0] REG_LIGHT_BLUE  = 8'd5;
    localparam logic [IDX_W-1:0] REG_LIGHT_BRT   = 8'd6;
    localparam logic [IDX_W-1:0] REG_DEF_ALPHA   = 8'd7;

    localparam logic [COL_W-1:0] DEF_ALPHA_RST = 8'd200;
    localparam logic [COL_W-1:0] COL_MAX       = 8'd255;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_div_st;

    // two root bits per call
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        t_sqrt_st         n;
        logic [REM_W-1:0] trial;
        n = s;
        for (int j = 0; j < 2; j++) begin
            n.rem = {n.rem[REM_W-3:0], n.rad[RAD_W-1 -: 2]};
            n.rad = {n.rad[RAD_W-3:0], 2'b00};
            trial = {n.root, 2'b01};
            if (n.rem >= trial) begin
                n.rem  = n.rem - trial;
                n.root = {n.root[ROOT_W-2:0], 1'b1};
            end else begin
                n.root = {n.root[ROOT_W-2:0], 1'b0};
            end
        end
        return n;
    endfunction

    // two quotient bits per call, starting at bit hi
    function automatic t_div_st div_step(input t_div_st s, input logic [DEN_W-1:0] den,
                                         input logic [2:0] hi);
        t_div_st           n;
        logic [PROD_W-1:0] sh;
        logic [2:0]        b;
        n = s;
        for (int j = 0; j < 2; j++) begin
            b  = hi - 3'(j);
            sh = {{(PROD_W-DEN_W){1'b0}}, den} << b;
            if (n.rem >= sh) begin
                n.rem    = n.rem - sh;
                n.quo[b] = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

@@ design/rlts_if.sv @@
// ----------------------------------------------------------------------------
// rlts_if
// Handshake channels of the radial light shader: tile in, shade out, config.
// ----------------------------------------------------------------------------
interface rlts_in_if;
    logic                         valid;
    logic                         ready;
    logic [rlts_pkg::TILE_W-1:0] tile_x;
    logic [rlts_pkg::TILE_W-1:0] tile_y;
    modport source (output valid, output tile_x, output tile_y, input ready);
    modport sink   (input valid, input tile_x, input tile_y, output ready);
endinterface

interface rlts_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlts_pkg::COL_W-1:0] out_red;
    logic [rlts_pkg::COL_W-1:0] out_green;
    logic [rlts_pkg::COL_W-1:0] out_blue;
    logic [rlts_pkg::COL_W-1:0] out_alpha;
    logic                        in_light;
    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output in_light, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input in_light, output ready);
endinterface

interface rlts_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rlts_pkg::IDX_W-1:0] index;
    logic [rlts_pkg::CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/rlts_isqrt.sv @@
// ----------------------------------------------------------------------------
// rlts_isqrt
// Pipelined integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module rlts_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rlts_pkg::RAD_W-1:0]      i_rad,
    output logic [rlts_pkg::ROOT_W-1:0]     o_root
);

    rlts_pkg::t_sqrt_st w_prev [rlts_pkg::SQRT_STAGES];
    rlts_pkg::t_sqrt_st r_st   [rlts_pkg::SQRT_STAGES];

    assign w_prev[0] = '{rad: i_rad, rem: '0, root: '0};

    for (genvar k = 0; k < rlts_pkg::SQRT_STAGES; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign w_prev[k] = r_st[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= rlts_pkg::sqrt_step(w_prev[k]);
            end
        end
    end

    assign o_root = r_st[rlts_pkg::SQRT_STAGES-1].root;

endmodule

@@ design/rlts_div.sv @@
// ----------------------------------------------------------------------------
// rlts_div
// Pipelined restoring divider, 8-bit quotient, two bits per stage.
// ----------------------------------------------------------------------------
module rlts_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rlts_pkg::PROD_W-1:0]    i_num,
    input  logic [rlts_pkg::DEN_W-1:0]     i_den,
    output logic [rlts_pkg::QUO_W-1:0]     o_quo,
    output logic                           o_rem_nz
);

    rlts_pkg::t_div_st w_prev [rlts_pkg::DIV_STAGES];
    rlts_pkg::t_div_st r_st   [rlts_pkg::DIV_STAGES];

    assign w_prev[0] = '{rem: i_num, quo: '0};

    for (genvar k = 0; k < rlts_pkg::DIV_STAGES; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign w_prev[k] = r_st[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= rlts_pkg::div_step(w_prev[k], i_den,
                                              3'(rlts_pkg::QUO_W - 1 - 2 * k));
            end
        end
    end

    assign o_quo    = r_st[rlts_pkg::DIV_STAGES-1].quo;
    assign o_rem_nz = |r_st[rlts_pkg::DIV_STAGES-1].rem;

endmodule

@@ design/radial_light_tile_shader.sv @@
// ----------------------------------------------------------------------------
// radial_light_tile_shader
// Shades screen tiles with a single light of linear radial falloff.
// ----------------------------------------------------------------------------
// One tile is taken per clock while the output is not stalled; the pipeline
// depth is three stages of distance and squaring, nine of square root (two
// root bits each), one compare, one multiply, four of division (two quotient
// bits each) and the output register. The whole pipeline advances together
// whenever the output register is empty or its contents are being taken, so a
// stall on the output holds every stage. Registers are written through the
// config channel only while no tile is in flight; the user must keep to this,
// the block itself does not enforce it. They are read live by the stages.
module radial_light_tile_shader #(
    parameter int COORD_BITS = rlts_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlts_in_if.sink           i_tile,
    rlts_out_if.source        o_shade,
    rlts_cfg_if.sink          i_cfg
);

    localparam int LAT = 3 + rlts_pkg::SQRT_STAGES + 2 + rlts_pkg::DIV_STAGES + 1;
    localparam logic [rlts_pkg::RANGE_W-1:0] RANGE_MASK =
        rlts_pkg::RANGE_W'((64'd1 << COORD_BITS) - 64'd1);

    function automatic logic signed [rlts_pkg::DIFF_W-1:0] DIFF_W_SEXT(
        input logic signed [rlts_pkg::POS_W-1:0] v);
        return {v[rlts_pkg::POS_W-1], v};
    endfunction

    // configuration registers
    logic signed [rlts_pkg::POS_W-1:0]   r_light_x;
    logic signed [rlts_pkg::POS_W-1:0]   r_light_y;
    logic        [rlts_pkg::RANGE_W-1:0] r_range;
    logic        [rlts_pkg::COL_W-1:0]   r_red, r_green, r_blue, r_brt, r_def_alpha;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x   <= '0;
            r_light_y   <= '0;
            r_range     <= '0;
            r_red       <= '0;
            r_green     <= '0;
            r_blue      <= '0;
            r_brt       <= '0;
            r_def_alpha <= rlts_pkg::DEF_ALPHA_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rlts_pkg::REG_LIGHT_X:     r_light_x   <= i_cfg.data;
                rlts_pkg::REG_LIGHT_Y:     r_light_y   <= i_cfg.data;
                rlts_pkg::REG_LIGHT_RANGE: r_range     <= i_cfg.data[11:0] & RANGE_MASK;
                rlts_pkg::REG_LIGHT_RED:   r_red       <= i_cfg.data[7:0];
                rlts_pkg::REG_LIGHT_GREEN: r_green     <= i_cfg.data[7:0];
                rlts_pkg::REG_LIGHT_BLUE:  r_blue      <= i_cfg.data[7:0];
                rlts_pkg::REG_LIGHT_BRT:   r_brt       <= i_cfg.data[7:0];
                rlts_pkg::REG_DEF_ALPHA:   r_def_alpha <= i_cfg.data[7:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // global advance: move everything when the output slot frees up
    logic           w_en;
    logic [LAT-1:0] r_valid;

    assign w_en         = !r_valid[LAT-1] || o_shade.ready;
    assign i_tile.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[LAT-2:0], i_tile.valid};
        end
    end

    // radius scaled by 16 to match the four fraction bits of the root
    logic [rlts_pkg::DEN_W-1:0] w_r16;
    assign w_r16 = {r_range, 4'b0000};

    // stage 1: absolute offsets
    logic signed [rlts_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [rlts_pkg::ABS_W-1:0]         r_adx, r_ady;

    assign w_dx = $signed({3'b000, i_tile.tile_x}) - DIFF_W_SEXT(r_light_x);
    assign w_dy = $signed({3'b000, i_tile.tile_y}) - DIFF_W_SEXT(r_light_y);

    // stage 2: squares; stage 3: sum scaled by 256
    logic [rlts_pkg::SQ_W-1:0]  r_sqx, r_sqy;
    logic [rlts_pkg::RAD_W-1:0] r_rad;
    logic [rlts_pkg::DIFF_W-1:0] w_adx_full, w_ady_full;

    assign w_adx_full = w_dx[rlts_pkg::DIFF_W-1] ? 14'(-w_dx) : 14'(w_dx);
    assign w_ady_full = w_dy[rlts_pkg::DIFF_W-1] ? 14'(-w_dy) : 14'(w_dy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_adx <= w_adx_full[rlts_pkg::ABS_W-1:0];
            r_ady <= w_ady_full[rlts_pkg::ABS_W-1:0];
            r_sqx <= r_adx * r_adx;
            r_sqy <= r_ady * r_ady;
            r_rad <= {1'b0, rlts_pkg::SUM_W'(r_sqx) + rlts_pkg::SUM_W'(r_sqy), 8'h00};
        end
    end

    // distance in 1/16 pixel
    logic [rlts_pkg::ROOT_W-1:0] w_d16;

    rlts_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rad),
        .o_root (w_d16)
    );

    // compare against range, then scale each channel by the remaining distance
    logic                         r_lit, r_lit_p;
    logic [rlts_pkg::DEN_W-1:0]   r_num;
    logic [rlts_pkg::PROD_W-1:0]  r_prod [4];
    logic                         r_lit_d [rlts_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lit     <= (w_d16 < rlts_pkg::ROOT_W'(w_r16));
            r_num     <= w_r16 - w_d16[rlts_pkg::DEN_W-1:0];
            r_prod[0] <= r_red   * r_num;
            r_prod[1] <= r_green * r_num;
            r_prod[2] <= r_blue  * r_num;
            r_prod[3] <= r_brt   * r_num;
            r_lit_p   <= r_lit;
            r_lit_d[0] <= r_lit_p;
            for (int k = 1; k < rlts_pkg::DIV_STAGES; k++) begin
                r_lit_d[k] <= r_lit_d[k-1];
            end
        end
    end

    logic [rlts_pkg::QUO_W-1:0] w_quo    [4];
    logic                       w_rem_nz [4];

    for (genvar c = 0; c < 4; c++) begin : g_div
        rlts_div u_div (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_num    (r_prod[c]),
            .i_den    (w_r16),
            .o_quo    (w_quo[c]),
            .o_rem_nz (w_rem_nz[c])
        );
    end

    // alpha: 255 minus the rounded-up brightness share, capped at the default
    logic [rlts_pkg::COL_W:0]   w_bq;
    logic [rlts_pkg::COL_W:0]   w_alpha_raw;
    logic [rlts_pkg::COL_W-1:0] w_alpha;
    logic                       w_lit;

    assign w_lit       = r_lit_d[rlts_pkg::DIV_STAGES-1];
    assign w_bq        = {1'b0, w_quo[3]} + 9'(w_rem_nz[3]);
    assign w_alpha_raw = {1'b0, rlts_pkg::COL_MAX} - w_bq;
    assign w_alpha     = (w_alpha_raw > {1'b0, r_def_alpha}) ? r_def_alpha
                                                             : w_alpha_raw[7:0];

    logic [rlts_pkg::COL_W-1:0] r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic                       r_o_lit;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_red   <= w_lit ? w_quo[0] : '0;
            r_o_green <= w_lit ? w_quo[1] : '0;
            r_o_blue  <= w_lit ? w_quo[2] : '0;
            r_o_alpha <= w_lit ? w_alpha  : r_def_alpha;
            r_o_lit   <= w_lit;
        end
    end

    assign o_shade.valid     = r_valid[LAT-1];
    assign o_shade.out_red   = r_o_red;
    assign o_shade.out_green = r_o_green;
    assign o_shade.out_blue  = r_o_blue;
    assign o_shade.out_alpha = r_o_alpha;
    assign o_shade.in_light  = r_o_lit;

    // unlit tiles are black at the default alpha
    a_unlit_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shade.valid && !o_shade.in_light |->
            o_shade.out_red == '0 && o_shade.out_green == '0 &&
            o_shade.out_blue == '0 && o_shade.out_alpha == r_def_alpha)
        else $error("unlit tile not black at default alpha");

    // lit alpha never exceeds the cap
    a_alpha_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shade.valid && o_shade.in_light |-> o_shade.out_alpha <= r_def_alpha)
        else $error("lit alpha above default alpha");

    // a zero range lights nothing
    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shade.valid && o_shade.in_light |-> r_range != '0)
        else $error("tile lit with zero range");

    // a stall freezes the valid chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_valid))
        else $error("pipeline moved during stall");

endmodule

@@ tb/tb_rlts_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rlts_if
// The testbench drives the channel interfaces of the design folder (tile in,
// shade out and register writes); no channel is declared here.
// ----------------------------------------------------------------------------

@@ tb/tb_radial_light_tile_shader.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_light_tile_shader
// Drives tiles through the radial light shader under several light settings
// and idling patterns, and checks every shade against a local predictor.
// ----------------------------------------------------------------------------
module tb_radial_light_tile_shader;

    typedef struct packed {
        logic [rlts_pkg::COL_W-1:0] red;
        logic [rlts_pkg::COL_W-1:0] green;
        logic [rlts_pkg::COL_W-1:0] blue;
        logic [rlts_pkg::COL_W-1:0] alpha;
        logic                       lit;
    } t_shade;

    typedef struct packed {
        logic [rlts_pkg::TILE_W-1:0] tx;
        logic [rlts_pkg::TILE_W-1:0] ty;
        logic                        has_exp;
        t_shade                      shade;
    } t_tile_row;

    localparam int PIPE_LAT = 19;

    logic i_clk;
    logic i_rst_n;

    rlts_in_if  tile_ch ();
    rlts_out_if shade_ch ();
    rlts_cfg_if cfg_ch ();

    radial_light_tile_shader uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tile  (tile_ch.sink),
        .o_shade (shade_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // local copy of the light registers
    int          lx, ly;
    int unsigned lrange, lred, lgreen, lblue, lbrt, ldef;

    t_shade shade_q[$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // falloff shade of one tile under the current light
    function automatic t_shade shade_of(input logic [rlts_pkg::TILE_W-1:0] tx,
                                        input logic [rlts_pkg::TILE_W-1:0] ty);
        t_shade          s;
        longint          dx, dy;
        longint unsigned dist16, rad16, num, bn, bq, al;
        dx = longint'(tx) - lx;
        dy = longint'(ty) - ly;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        dist16 = root_floor(longint'((dx * dx + dy * dy) << 8));
        rad16  = longint'(lrange) << 4;
        if (dist16 < rad16) begin
            num = rad16 - dist16;
            bn  = lbrt * num;
            bq  = bn / rad16;
            if (bq * rad16 != bn) bq++;
            al = 255 - bq;
            if (al > ldef) al = ldef;
            s.red   = rlts_pkg::COL_W'((lred * num) / rad16);
            s.green = rlts_pkg::COL_W'((lgreen * num) / rad16);
            s.blue  = rlts_pkg::COL_W'((lblue * num) / rad16);
            s.alpha = rlts_pkg::COL_W'(al);
            s.lit   = 1'b1;
        end else begin
            s = '0;
            s.alpha = rlts_pkg::COL_W'(ldef);
        end
        return s;
    endfunction

    // write one register while the pipeline is empty
    task automatic write_reg(input logic [rlts_pkg::IDX_W-1:0] idx,
                             input logic [rlts_pkg::CFG_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            rlts_pkg::REG_LIGHT_X:     lx = int'($signed(val));
            rlts_pkg::REG_LIGHT_Y:     ly = int'($signed(val));
            rlts_pkg::REG_LIGHT_RANGE: lrange = val[rlts_pkg::RANGE_W-1:0];
            rlts_pkg::REG_LIGHT_RED:   lred = val[rlts_pkg::COL_W-1:0];
            rlts_pkg::REG_LIGHT_GREEN: lgreen = val[rlts_pkg::COL_W-1:0];
            rlts_pkg::REG_LIGHT_BLUE:  lblue = val[rlts_pkg::COL_W-1:0];
            rlts_pkg::REG_LIGHT_BRT:   lbrt = val[rlts_pkg::COL_W-1:0];
            rlts_pkg::REG_DEF_ALPHA:   ldef = val[rlts_pkg::COL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_light(input int x, input int y, input int r, input int red,
                             input int grn, input int blu, input int brt, input int da);
        write_reg(rlts_pkg::REG_LIGHT_X, rlts_pkg::CFG_W'(x));
        write_reg(rlts_pkg::REG_LIGHT_Y, rlts_pkg::CFG_W'(y));
        write_reg(rlts_pkg::REG_LIGHT_RANGE, rlts_pkg::CFG_W'(r));
        write_reg(rlts_pkg::REG_LIGHT_RED, rlts_pkg::CFG_W'(red));
        write_reg(rlts_pkg::REG_LIGHT_GREEN, rlts_pkg::CFG_W'(grn));
        write_reg(rlts_pkg::REG_LIGHT_BLUE, rlts_pkg::CFG_W'(blu));
        write_reg(rlts_pkg::REG_LIGHT_BRT, rlts_pkg::CFG_W'(brt));
        write_reg(rlts_pkg::REG_DEF_ALPHA, rlts_pkg::CFG_W'(da));
    endtask

    // offer one tile, honouring the sender idle rate; queue its shade on transfer
    task automatic send_tile(input logic [rlts_pkg::TILE_W-1:0] tx,
                             input logic [rlts_pkg::TILE_W-1:0] ty);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        tile_ch.valid  = 1'b1;
        tile_ch.tile_x = tx;
        tile_ch.tile_y = ty;
        do @(posedge i_clk); while (!tile_ch.ready);
        shade_q.insert(shade_q.size(), shade_of(tx, ty));
        @(negedge i_clk);
        tile_ch.valid = 1'b0;
    endtask

    // hold until every shade is back, then let the pipeline drain
    task automatic wait_drain();
        while (shade_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    // random tile, mostly near the light so that both sides of the range are hit
    task automatic random_tile();
        int tx, ty;
        if ($urandom_range(3) == 0) begin
            tx = $urandom_range(2047);
            ty = $urandom_range(2047);
        end else begin
            tx = lx + int'($urandom_range(2 * lrange + 2)) - int'(lrange) - 1;
            ty = ly + int'($urandom_range(2 * lrange + 2)) - int'(lrange) - 1;
            if (tx < 0) tx = 0;
            if (tx > 2047) tx = 2047;
            if (ty < 0) ty = 0;
            if (ty > 2047) ty = 2047;
        end
        send_tile(rlts_pkg::TILE_W'(tx), rlts_pkg::TILE_W'(ty));
    endtask

    // receiver: stall at random, compare each transfer with the oldest shade
    always @(negedge i_clk) begin
        shade_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && shade_ch.valid && shade_ch.ready) begin
            if (shade_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("shade transfer with none expected");
            end else begin
                want = shade_q.pop_front();
                if (shade_ch.out_red !== want.red || shade_ch.out_green !== want.green ||
                    shade_ch.out_blue !== want.blue || shade_ch.out_alpha !== want.alpha ||
                    shade_ch.in_light !== want.lit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("shade exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 want.red, want.green, want.blue, want.alpha, want.lit,
                                 shade_ch.out_red, shade_ch.out_green, shade_ch.out_blue,
                                 shade_ch.out_alpha, shade_ch.in_light);
                end
            end
        end
    end

    t_tile_row dir_rows[16];

    initial begin
        int phase, n;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lx = 0; ly = 0; lrange = 0; lred = 0; lgreen = 0; lblue = 0; lbrt = 0;
        ldef = rlts_pkg::DEF_ALPHA_RST;
        i_rst_n        = 1'b0;
        tile_ch.valid  = 1'b0;
        tile_ch.tile_x = '0;
        tile_ch.tile_y = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: range zero, so every tile is dark at the reset alpha
        dir_rows[0] = '{11'd0,    11'd0,    1'b1,
                        '{8'd0, 8'd0, 8'd0, rlts_pkg::DEF_ALPHA_RST, 1'b0}};
        dir_rows[1] = '{11'd2047, 11'd2047, 1'b1,
                        '{8'd0, 8'd0, 8'd0, rlts_pkg::DEF_ALPHA_RST, 1'b0}};
        for (int i = 0; i < 2; i++) begin
            shade_q.insert(shade_q.size(), dir_rows[i].shade);
            send_tile(dir_rows[i].tx, dir_rows[i].ty);
            void'(shade_q.pop_back());
        end
        // the predictor's view must agree with the typed-in rows
        for (int i = 0; i < 2; i++) begin
            if (shade_of(dir_rows[i].tx, dir_rows[i].ty) != dir_rows[i].shade) begin
                mismatches++;
                if (mismatches <= 10) $display("predictor disagrees with row %0d", i);
            end
        end
        wait_drain();

        // full white light at the origin, range 4095: the centre tile is full colour
        set_light(0, 0, 4095, 255, 255, 255, 255, 255);
        dir_rows[2] = '{11'd0,    11'd0,    1'b1, '{8'd255, 8'd255, 8'd255, 8'd0, 1'b1}};
        dir_rows[3] = '{11'd2047, 11'd0,    1'b0, '0};
        dir_rows[4] = '{11'd0,    11'd2047, 1'b0, '0};
        dir_rows[5] = '{11'd2047, 11'd2047, 1'b0, '0};
        dir_rows[6] = '{11'h555,  11'h2AA,  1'b0, '0};
        for (int i = 2; i < 7; i++) begin
            if (dir_rows[i].has_exp && shade_of(dir_rows[i].tx, dir_rows[i].ty)
                                       != dir_rows[i].shade) begin
                mismatches++;
                if (mismatches <= 10) $display("predictor disagrees with row %0d", i);
            end
            send_tile(dir_rows[i].tx, dir_rows[i].ty);
        end
        wait_drain();

        // light at the far negative corner, range 1; then at the positive extreme
        set_light(-4096, -4096, 1, 17, 34, 51, 128, 0);
        send_tile(11'd0, 11'd0);
        wait_drain();
        write_reg(rlts_pkg::REG_LIGHT_X, 13'd5);
        write_reg(rlts_pkg::REG_LIGHT_Y, 13'd7);
        send_tile(11'd5, 11'd7);
        send_tile(11'd6, 11'd7);
        send_tile(11'd5, 11'd6);
        wait_drain();
        set_light(4095, 4095, 4095, 200, 100, 50, 0, 200);
        send_tile(11'd2047, 11'd2047);
        send_tile(11'd0, 11'd0);
        wait_drain();
        // unused register index: write is dropped
        write_reg(8'hFF, 13'h1FFF);
        send_tile(11'd2047, 11'd0);
        wait_drain();

        // random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            set_light(int'($urandom_range(2047)) - (phase == 5 ? 4096 : 0),
                      int'($urandom_range(2047)) + (phase == 6 ? 2048 : 0),
                      (phase == 7) ? 0 : $urandom_range(4095) >> $urandom_range(5),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
            n = 150;
            for (int k = 0; k < n; k++) begin
                random_tile();
                // pause once until every shade is back
                if (phase == 1 && k == 60) while (shade_q.size() != 0) @(negedge i_clk);
            end
            wait_drain();
        end

        recv_stall_pct = 0;
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/rlts_pkg.sv
design/rlts_if.sv
design/rlts_isqrt.sv
design/rlts_div.sv
design/radial_light_tile_shader.sv
tb/tb_rlts_if.sv
tb/tb_radial_light_tile_shader.sv
